/* rtl/core/cpvpid_pkg.sv */
// Package for the cascaded position/velocity PID controller.
// Holds request/result payload types, register indexes, limits and a saturation helper.
// No dependencies.
package cpvpid_pkg;

  localparam int DATA_W     = 24;
  localparam int CFG_ADDR_W = 3;

  // Outer loop limits.
  localparam int INTEGRAL_UPPER = 1280000;
  localparam int INTEGRAL_LOWER = -1280000;
  localparam int COMMAND_UPPER  = 8388607;
  localparam int COMMAND_LOWER  = -8388608;

  // Dead band thresholds in Q16.8: 1.0 and 30.0.
  localparam int ONE_Q8    = 256;
  localparam int THIRTY_Q8 = 7680;

  // Fractional bits dropped from a Q8.16 x Q16.8 product.
  localparam int GAIN_FRAC = 16;

  typedef logic signed [DATA_W-1:0] word_t;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_OUTER_KP  = 3'd0,
    CFG_OUTER_KI  = 3'd1,
    CFG_OUTER_KD  = 3'd2,
    CFG_INNER_KP  = 3'd3,
    CFG_INNER_KI  = 3'd4,
    CFG_INNER_KD  = 3'd5,
    CFG_DRIVE_MAX = 3'd6,
    CFG_DRIVE_MIN = 3'd7
  } cfg_idx_t;

  // Input request payload.
  typedef struct packed {
    word_t position_target;
    word_t position_feedback;
    word_t velocity_feedback;
  } in_req_t;

  // Result payload.
  typedef struct packed {
    word_t drive_value;
    word_t velocity_command;
  } out_rsp_t;

  // Saturate a 25-bit signed difference to the 24-bit signed range.
  function automatic word_t sat_25(logic signed [DATA_W:0] v);
    word_t res;
    res = v[DATA_W-1:0];
    if (v[DATA_W] != v[DATA_W-1]) begin
      res = v[DATA_W] ? word_t'({1'b1, {(DATA_W-1){1'b0}}})
                      : word_t'({1'b0, {(DATA_W-1){1'b1}}});
    end
    return res;
  endfunction

endpackage

/* rtl/core/cascade_position_velocity_pid_top.sv */
// Top level of the cascaded position/velocity PID controller.
// Uses cpvpid_pkg for payload types, register indexes and constants.
// Channel  Direction  Signals                            Payload
// in       input      in_valid / in_ready / in_data      in_req_t (target, feedbacks)
// out      output     out_valid / out_ready / out_data   out_rsp_t (drive, velocity cmd)
// cfg      input      cfg_we / cfg_addr / cfg_wdata      one 24-bit register per index
//
// Each request is stepped through by the state machine, which skips the velocity loop steps
// when that loop is idle: all six gain products go through a single 24 x 27 multiplier
// with a registered product and an accumulator.
// in_ready is high only in the idle state, in the cycle after the result is loaded; a finished
// result waits in the output register, and a new request is taken meanwhile. Reset is
// synchronous, active low, clears the loop state and the gains, and opens the drive limits.
module cascade_position_velocity_pid_top
  import cpvpid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_rsp_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0]     cfg_wdata
);

  localparam int MUL_B_W = DATA_W + 3;
  localparam int PROD_W  = DATA_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int SHR_W   = ACC_W - GAIN_FRAC;
  localparam int DRV_W   = SHR_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_OERR, ST_OINT, ST_OM0, ST_OM1, ST_OM2, ST_OACC, ST_OCMD,
    ST_IERR, ST_IM0, ST_IM1, ST_IM2, ST_IACC, ST_IDRV, ST_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  word_t okp_r, oki_r, okd_r, ikp_r, iki_r, ikd_r, drv_max_r, drv_min_r;

  // Loop state.
  word_t integral_r, last_o_r, acc_out_r, last_i_r, bl_i_r;

  // Working registers for the request in flight.
  in_req_t                   req_r;
  word_t                     err_o_r, err_i_r, cmd_r, drive_r;
  logic                      dead_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      out_valid_r;
  out_rsp_t                  out_data_r;
  logic                      out_load;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The result register takes a new result when it is empty or being emptied.
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // Position error with its dead band.
  logic signed [DATA_W:0] pos_diff;
  word_t                  err_o_nxt;
  logic                   dead_nxt;

  always_comb begin
    pos_diff  = {req_r.position_target[DATA_W-1], req_r.position_target}
              - {req_r.position_feedback[DATA_W-1], req_r.position_feedback};
    err_o_nxt = sat_25(pos_diff);
    dead_nxt  = (err_o_nxt > -word_t'(ONE_Q8)) && (err_o_nxt < word_t'(ONE_Q8));
  end

  // Integral update and clamp.
  logic signed [DATA_W:0] int_sum;
  word_t                  integral_nxt;

  always_comb begin
    int_sum = (dead_r ? '0 : {integral_r[DATA_W-1], integral_r})
            + {err_o_r[DATA_W-1], err_o_r};
    integral_nxt = int_sum[DATA_W-1:0];
    if (int_sum > (DATA_W+1)'(INTEGRAL_UPPER)) begin
      integral_nxt = word_t'(INTEGRAL_UPPER);
    end
    if (int_sum < (DATA_W+1)'(INTEGRAL_LOWER)) begin
      integral_nxt = word_t'(INTEGRAL_LOWER);
    end
  end

  // Scaled accumulator, velocity command clamp.
  logic signed [SHR_W-1:0] acc_shr;
  word_t                   cmd_nxt;

  always_comb begin
    acc_shr = acc_r[ACC_W-1:GAIN_FRAC];
    cmd_nxt = acc_shr[DATA_W-1:0];
    if (acc_shr > SHR_W'(COMMAND_UPPER)) begin
      cmd_nxt = word_t'(COMMAND_UPPER);
    end
    if (acc_shr < SHR_W'(COMMAND_LOWER)) begin
      cmd_nxt = word_t'(COMMAND_LOWER);
    end
  end

  // Velocity error and the idle test of the inner loop.
  logic signed [DATA_W:0] vel_diff;
  word_t                  err_i_nxt;
  logic                   inner_idle;

  always_comb begin
    vel_diff   = {cmd_r[DATA_W-1], cmd_r}
               - {req_r.velocity_feedback[DATA_W-1], req_r.velocity_feedback};
    err_i_nxt  = sat_25(vel_diff);
    inner_idle = (cmd_r > -word_t'(ONE_Q8)) && (cmd_r < word_t'(ONE_Q8))
              && (req_r.velocity_feedback > -word_t'(THIRTY_Q8))
              && (req_r.velocity_feedback < word_t'(THIRTY_Q8));
  end

  // Drive accumulation and clamp against the programmed limits. The lower limit is
  // tested against the already capped value, so it wins when the limits cross.
  logic signed [DRV_W-1:0] drv_sum;
  logic signed [DRV_W-1:0] drv_cap;
  word_t                   drive_nxt;

  always_comb begin
    drv_sum = DRV_W'(acc_out_r) + DRV_W'(acc_shr);
    drv_cap = drv_sum;
    if (drv_sum > DRV_W'(drv_max_r)) begin
      drv_cap = DRV_W'(drv_max_r);
    end
    if (drv_cap < DRV_W'(drv_min_r)) begin
      drv_cap = DRV_W'(drv_min_r);
    end
    drive_nxt = drv_cap[DATA_W-1:0];
  end

  // Operand selection for the shared multiplier.
  word_t                    mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_OM0: begin
        mul_a = okp_r;
        mul_b = MUL_B_W'(err_o_r);
      end
      ST_OM1: begin
        mul_a = oki_r;
        mul_b = MUL_B_W'(integral_r);
      end
      ST_OM2: begin
        mul_a = okd_r;
        mul_b = MUL_B_W'(err_o_r) - MUL_B_W'(last_o_r);
      end
      ST_IM0: begin
        mul_a = ikp_r;
        mul_b = MUL_B_W'(err_i_r) - MUL_B_W'(last_i_r);
      end
      ST_IM1: begin
        mul_a = iki_r;
        mul_b = MUL_B_W'(err_i_r);
      end
      ST_IM2: begin
        mul_a = ikd_r;
        mul_b = MUL_B_W'(err_i_r) - (MUL_B_W'(last_i_r) <<< 1) + MUL_B_W'(bl_i_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      okp_r     <= '0;
      oki_r     <= '0;
      okd_r     <= '0;
      ikp_r     <= '0;
      iki_r     <= '0;
      ikd_r     <= '0;
      drv_max_r <= word_t'(COMMAND_UPPER);
      drv_min_r <= word_t'(COMMAND_LOWER);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_OUTER_KP:  okp_r     <= cfg_wdata;
        CFG_OUTER_KI:  oki_r     <= cfg_wdata;
        CFG_OUTER_KD:  okd_r     <= cfg_wdata;
        CFG_INNER_KP:  ikp_r     <= cfg_wdata;
        CFG_INNER_KI:  iki_r     <= cfg_wdata;
        CFG_INNER_KD:  ikd_r     <= cfg_wdata;
        CFG_DRIVE_MAX: drv_max_r <= cfg_wdata;
        CFG_DRIVE_MIN: drv_min_r <= cfg_wdata;
        default:       okp_r     <= okp_r;
      endcase
    end
  end

  // Datapath without reset: request copy, product and accumulator.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    prod_r <= mul_p;
    unique case (state_r)
      ST_OM0, ST_IM0: acc_r <= '0;
      ST_OM1, ST_OM2, ST_OACC, ST_IM1, ST_IM2, ST_IACC: acc_r <= acc_r + ACC_W'(prod_r);
      default: acc_r <= acc_r;
    endcase
  end

  // Sequencer, loop state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      integral_r  <= '0;
      last_o_r    <= '0;
      acc_out_r   <= '0;
      last_i_r    <= '0;
      bl_i_r      <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_OERR;
          end
        end
        ST_OERR: begin
          err_o_r <= dead_nxt ? '0 : err_o_nxt;
          dead_r  <= dead_nxt;
          state_r <= ST_OINT;
        end
        ST_OINT: begin
          integral_r <= integral_nxt;
          state_r    <= ST_OM0;
        end
        ST_OM0:  state_r <= ST_OM1;
        ST_OM1:  state_r <= ST_OM2;
        ST_OM2:  state_r <= ST_OACC;
        ST_OACC: state_r <= ST_OCMD;
        ST_OCMD: begin
          cmd_r    <= cmd_nxt;
          last_o_r <= err_o_r;
          state_r  <= ST_IERR;
        end
        ST_IERR: begin
          if (inner_idle) begin
            acc_out_r <= '0;
            last_i_r  <= '0;
            bl_i_r    <= '0;
            drive_r   <= '0;
            state_r   <= ST_OUT;
          end else begin
            err_i_r <= err_i_nxt;
            state_r <= ST_IM0;
          end
        end
        ST_IM0:  state_r <= ST_IM1;
        ST_IM1:  state_r <= ST_IM2;
        ST_IM2:  state_r <= ST_IACC;
        ST_IACC: state_r <= ST_IDRV;
        ST_IDRV: begin
          drive_r   <= drive_nxt;
          acc_out_r <= drive_nxt;
          bl_i_r    <= last_i_r;
          last_i_r  <= err_i_r;
          state_r   <= ST_OUT;
        end
        ST_OUT: begin
          // Load the result once the output register is free.
          if (out_load) begin
            out_data_r.drive_value      <= drive_r;
            out_data_r.velocity_command <= cmd_r;
            state_r                     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* tb/tb_cascade_position_velocity_pid_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the cascaded position/velocity PID controller.
// Depends on cpvpid_pkg and cascade_position_velocity_pid_top; a predictor checks results.
module tb_cascade_position_velocity_pid_top;
  import cpvpid_pkg::*;

  localparam word_t W_MAX = 24'sh7FFFFF;
  localparam word_t W_MIN = 24'sh800000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int DRAIN_CYCLES    = 24;
  localparam int LONG_HOLD       = 400;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int DIR_ROWS        = 22;
  localparam int DIR_B_START     = 7;
  localparam int DIR_C_START     = 18;

  // One row of directed stimulus; known rows carry their expected result.
  typedef struct packed {
    word_t goal_pos;
    word_t meas_pos;
    word_t meas_vel;
    logic  known;
    word_t drive;
    word_t vcmd;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_rsp_t out_data;
  logic     cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [DATA_W-1:0]     cfg_wdata;

  // Predictor copy of the registers and of the loop state.
  word_t cfg_regs [8];
  word_t outer_integ;
  word_t outer_prev_err;
  word_t drive_acc;
  word_t inner_prev_err;
  word_t inner_prev2_err;

  out_rsp_t expected_drive_cmds [$];
  int       mismatch_count;
  int       burst_left;
  bit       long_hold_req;

  // Rows before DIR_B_START run with reset gains, so every result is zero.
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{24'sd0, 24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
    '{W_MAX, W_MIN, 24'sd0, 1'b1, 24'sd0, 24'sd0},
    '{W_MIN, W_MAX, W_MAX, 1'b1, 24'sd0, 24'sd0},
    '{W_MIN, W_MIN, W_MIN, 1'b1, 24'sd0, 24'sd0},
    '{24'sd255, 24'sd0, 24'sd7679, 1'b1, 24'sd0, 24'sd0},
    '{24'sd0, 24'sd256, -24'sd7680, 1'b1, 24'sd0, 24'sd0},
    '{W_MAX, W_MAX, 24'sd7680, 1'b1, 24'sd0, 24'sd0},
    '{24'sd1000, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
    '{24'sd1000, 24'sd200, 24'sd0, 1'b0, 24'sd0, 24'sd0},
    '{24'sd100, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
    '{24'sd0, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
    '{24'sd0, 24'sd0, 24'sd100, 1'b0, 24'sd0, 24'sd0},
    '{24'sd0, 24'sd0, 24'sd8000, 1'b0, 24'sd0, 24'sd0},
    '{W_MAX, W_MIN, 24'sd0, 1'b0, 24'sd0, 24'sd0},
    '{W_MAX, W_MIN, W_MIN, 1'b0, 24'sd0, 24'sd0},
    '{W_MIN, W_MAX, W_MAX, 1'b0, 24'sd0, 24'sd0},
    '{-24'sd300, 24'sd0, -24'sd7679, 1'b0, 24'sd0, 24'sd0},
    '{24'sd300, 24'sd0, 24'sd7679, 1'b0, 24'sd0, 24'sd0},
    '{24'sd5000, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
    '{-24'sd5000, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
    '{24'sd0, 24'sd0, 24'sd9000, 1'b0, 24'sd0, 24'sd0},
    '{24'sd0, 24'sd0, -24'sd9000, 1'b0, 24'sd0, 24'sd0}
  };

  cascade_position_velocity_pid_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Free-running 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturate a wide value to the signed 24-bit range.
  function automatic longint clip24(longint v);
    if (v > longint'(W_MAX)) return longint'(W_MAX);
    if (v < longint'(W_MIN)) return longint'(W_MIN);
    return v;
  endfunction

  // Random signed value in [-span, span].
  function automatic word_t rand_signed(int unsigned span);
    return word_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  // Advance both loops by one sample and return the drive and velocity command.
  function automatic out_rsp_t predict_control(in_req_t req);
    longint err, acc, sum, cmd, vel, verr, drive;
    out_rsp_t rsp;
    // Position loop with dead band, integral clamp and command clamp.
    err = clip24(longint'(req.position_target) - longint'(req.position_feedback));
    if (err > -ONE_Q8 && err < ONE_Q8) begin
      err = 0;
      outer_integ = '0;
    end
    acc = longint'(outer_integ) + err;
    if (acc > INTEGRAL_UPPER) acc = INTEGRAL_UPPER;
    if (acc < INTEGRAL_LOWER) acc = INTEGRAL_LOWER;
    outer_integ = word_t'(acc);
    sum = longint'(cfg_regs[CFG_OUTER_KP]) * err
        + longint'(cfg_regs[CFG_OUTER_KI]) * acc
        + longint'(cfg_regs[CFG_OUTER_KD]) * (err - longint'(outer_prev_err));
    cmd = sum >>> GAIN_FRAC;
    if (cmd > COMMAND_UPPER) cmd = COMMAND_UPPER;
    if (cmd < COMMAND_LOWER) cmd = COMMAND_LOWER;
    cmd = clip24(cmd);
    outer_prev_err = word_t'(err);

    // Velocity loop: idles near standstill, otherwise incremental update.
    vel = longint'(req.velocity_feedback);
    if (cmd > -ONE_Q8 && cmd < ONE_Q8 && vel > -THIRTY_Q8 && vel < THIRTY_Q8) begin
      drive_acc       = '0;
      inner_prev_err  = '0;
      inner_prev2_err = '0;
      drive = 0;
    end else begin
      verr = clip24(cmd - vel);
      sum = longint'(cfg_regs[CFG_INNER_KP]) * (verr - longint'(inner_prev_err))
          + longint'(cfg_regs[CFG_INNER_KI]) * verr
          + longint'(cfg_regs[CFG_INNER_KD])
            * (verr - 2 * longint'(inner_prev_err) + longint'(inner_prev2_err));
      drive = longint'(drive_acc) + (sum >>> GAIN_FRAC);
      if (drive > longint'(cfg_regs[CFG_DRIVE_MAX])) drive = longint'(cfg_regs[CFG_DRIVE_MAX]);
      if (drive < longint'(cfg_regs[CFG_DRIVE_MIN])) drive = longint'(cfg_regs[CFG_DRIVE_MIN]);
      drive = clip24(drive);
      drive_acc       = word_t'(drive);
      inner_prev2_err = inner_prev_err;
      inner_prev_err  = word_t'(verr);
    end
    rsp.drive_value      = word_t'(drive);
    rsp.velocity_command = word_t'(cmd);
    return rsp;
  endfunction

  // Write one register and mirror it in the predictor.
  task automatic write_register(cfg_idx_t idx, word_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    cfg_regs[idx] = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_settings(word_t okp, word_t oki, word_t okd, word_t ikp,
                               word_t iki, word_t ikd, word_t dmax, word_t dmin);
    write_register(CFG_OUTER_KP, okp);
    write_register(CFG_OUTER_KI, oki);
    write_register(CFG_OUTER_KD, okd);
    write_register(CFG_INNER_KP, ikp);
    write_register(CFG_INNER_KI, iki);
    write_register(CFG_INNER_KD, ikd);
    write_register(CFG_DRIVE_MAX, dmax);
    write_register(CFG_DRIVE_MIN, dmin);
  endtask

  // Offer one request, hold it until accepted, then queue its expected result.
  task automatic send_request(in_req_t req, bit use_typed, out_rsp_t typed_rsp);
    out_rsp_t rsp;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
    rsp = predict_control(req);
    if (use_typed) rsp = typed_rsp;
    expected_drive_cmds.push_back(rsp);
  endtask

  // Bursts of back-to-back requests separated by random gaps.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Stop offering and wait until every queued result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_drive_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result receiver: random stall modes, plus one long hold-off on request.
  initial begin : result_sink
    int mode;
    int span;
    int hold_count;
    int tick;
    bit hold_done;
    hold_count = 0;
    tick = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (long_hold_req && !hold_done) begin
          hold_count = LONG_HOLD;
          hold_done = 1'b1;
        end
        if (hold_count > 0) begin
          out_ready <= 1'b0;
          hold_count--;
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 1) != 0);
            default: out_ready <= (tick % 5 == 0);
          endcase
        end
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_drive_cmds.size() == 0) begin
        $error("unexpected result: drive_value %0d, velocity_command %0d",
               out_data.drive_value, out_data.velocity_command);
        mismatch_count++;
      end else begin
        want = expected_drive_cmds.pop_front();
        if (out_data.drive_value !== want.drive_value) begin
          $error("drive_value mismatch: expected %0d, actual %0d",
                 want.drive_value, out_data.drive_value);
          mismatch_count++;
        end
        if (out_data.velocity_command !== want.velocity_command) begin
          $error("velocity_command mismatch: expected %0d, actual %0d",
                 want.velocity_command, out_data.velocity_command);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, then randomized phases.
  initial begin : stimulus
    in_req_t  req;
    out_rsp_t typed;
    word_t    lim_a;
    word_t    lim_b;
    word_t    lim_t;
    int       kind;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    mismatch_count = 0;
    burst_left     = 0;
    long_hold_req  = 1'b0;
    for (int i = 0; i < 8; i++) cfg_regs[i] = '0;
    cfg_regs[CFG_DRIVE_MAX] = W_MAX;
    cfg_regs[CFG_DRIVE_MIN] = W_MIN;
    outer_integ     = '0;
    outer_prev_err  = '0;
    drive_acc       = '0;
    inner_prev_err  = '0;
    inner_prev2_err = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows; the later sections run with fixed gains, then crossed limits.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_B_START) begin
        drain_results();
        load_settings(24'sd65536, 24'sd256, 24'sd32768, 24'sd32768, 24'sd16384,
                      24'sd8192, 24'sd100000, -24'sd100000);
      end
      if (i == DIR_C_START) begin
        drain_results();
        load_settings(24'sd65536, 24'sd256, 24'sd32768, 24'sd32768, 24'sd16384,
                      24'sd8192, -24'sd1000, 24'sd1000);
      end
      req.position_target   = directed_rows[i].goal_pos;
      req.position_feedback = directed_rows[i].meas_pos;
      req.velocity_feedback = directed_rows[i].meas_vel;
      typed.drive_value      = directed_rows[i].drive;
      typed.velocity_command = directed_rows[i].vcmd;
      send_request(req, directed_rows[i].known, typed);
      pace_sender();
    end
    drain_results();

    // Random phases, each with its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      lim_a = word_t'($urandom());
      lim_b = word_t'($urandom());
      if (lim_a < lim_b) begin
        lim_t = lim_a;
        lim_a = lim_b;
        lim_b = lim_t;
      end
      case (p)
        0: load_settings(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN);
        1: load_settings(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, W_MIN);
        2: begin
          lim_t = word_t'($urandom_range(1000, 200000));
          load_settings(rand_signed(131072), rand_signed(131072), rand_signed(131072),
                        rand_signed(131072), rand_signed(131072), rand_signed(131072),
                        lim_t, -lim_t);
        end
        3: load_settings(rand_signed(65536), rand_signed(65536), rand_signed(65536),
                         rand_signed(65536), rand_signed(65536), rand_signed(65536),
                         -word_t'($urandom_range(0, 50000)),
                         word_t'($urandom_range(1, 50000)));
        5: load_settings(rand_signed(4096), rand_signed(4096), rand_signed(4096),
                         rand_signed(4096), rand_signed(4096), rand_signed(4096),
                         W_MAX, W_MIN);
        7: begin
          lim_t = rand_signed(50000);
          load_settings(rand_signed(262144), rand_signed(262144), rand_signed(262144),
                        rand_signed(262144), rand_signed(262144), rand_signed(262144),
                        lim_t, lim_t);
        end
        default: load_settings(word_t'($urandom()), word_t'($urandom()),
                               word_t'($urandom()), word_t'($urandom()),
                               word_t'($urandom()), word_t'($urandom()), lim_a, lim_b);
      endcase
      // The receiver holds off for a long stretch while requests keep coming.
      if (p == 2) long_hold_req = 1'b1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = $urandom_range(0, 9);
        case (kind)
          0: begin
            req.position_target   = word_t'($urandom());
            req.position_feedback = word_t'($urandom());
            req.velocity_feedback = word_t'($urandom());
          end
          1: begin
            // Field extremes, small values and the position dead band threshold.
            for (int f = 0; f < 3; f++) begin
              case ($urandom_range(0, 5))
                0: lim_t = W_MAX;
                1: lim_t = W_MIN;
                2: lim_t = 24'sd0;
                3: lim_t = -24'sd1;
                4: lim_t = 24'sd1;
                default: lim_t = 24'sd256;
              endcase
              case (f)
                0: req.position_target = lim_t;
                1: req.position_feedback = lim_t;
                default: req.velocity_feedback = lim_t;
              endcase
            end
          end
          2, 3: begin
            // Errors around the position dead band, low speed.
            req.position_target   = rand_signed(1 << 20);
            req.position_feedback = req.position_target + rand_signed(300);
            req.velocity_feedback = rand_signed(300);
          end
          4, 5, 6: begin
            // Ordinary tracking with moderate errors.
            req.position_target   = rand_signed(1 << 16);
            req.position_feedback = req.position_target + rand_signed(4096);
            req.velocity_feedback = rand_signed(10000);
          end
          7: begin
            // Speed right at the velocity idle threshold.
            req.position_target   = rand_signed(1 << 16);
            req.position_feedback = req.position_target + rand_signed(255);
            lim_t = word_t'(THIRTY_Q8 - 2 + int'($urandom_range(0, 3)));
            req.velocity_feedback = $urandom_range(0, 1) ? lim_t : -lim_t;
          end
          default: begin
            req.position_target   = rand_signed(1 << 20);
            req.position_feedback = rand_signed(1 << 20);
            req.velocity_feedback = rand_signed(1 << 16);
          end
        endcase
        send_request(req, 1'b0, '0);
        pace_sender();
      end
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
